FILE: hdl/footswitch_loop_preset_controller_unit_assert.svh
// Assertion macros used by the footswitch controller checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef FOOTSWITCH_LOOP_PRESET_CONTROLLER_UNIT_ASSERT_SVH
`define FOOTSWITCH_LOOP_PRESET_CONTROLLER_UNIT_ASSERT_SVH

// Property checked outside reset only.
`define FSC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Property checked on every edge, reset included.
`define FSC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hdl/fsc_pkg.sv
// Shared constants, types and decode functions of the footswitch controller.
// No dependencies.
package fsc_pkg;

    localparam int NUM_BANKS        = 4;
    localparam int PRESETS_PER_BANK = 8;

    localparam int CODE_W  = 5;
    localparam int MASK_W  = 8;
    localparam int BANK_W  = 2;
    localparam int IDX_W   = 3;
    localparam int SLOT_W  = 4;
    localparam int ADDR_W  = 5;
    localparam int DEPTH   = 32;
    localparam int KIND_W  = 3;

    localparam logic [CODE_W-1:0] CODE_BYPASS = 5'b11110;
    localparam logic [CODE_W-1:0] CODE_MODE   = 5'b11000;
    localparam logic [CODE_W-1:0] CODE_BANK   = 5'b00011;
    localparam logic [CODE_W-1:0] CODE_NONE   = 5'b11111;
    localparam logic [CODE_W-1:0] CODE_ALL    = 5'b00000;

    localparam logic [CODE_W-1:0] CODE_SLOT0 = 5'b11100;
    localparam logic [CODE_W-1:0] CODE_SLOT1 = 5'b11101;
    localparam logic [CODE_W-1:0] CODE_SLOT2 = 5'b11001;
    localparam logic [CODE_W-1:0] CODE_SLOT3 = 5'b11011;
    localparam logic [CODE_W-1:0] CODE_SLOT4 = 5'b10011;
    localparam logic [CODE_W-1:0] CODE_SLOT5 = 5'b10111;
    localparam logic [CODE_W-1:0] CODE_SLOT6 = 5'b00111;
    localparam logic [CODE_W-1:0] CODE_SLOT7 = 5'b01111;

    localparam logic [SLOT_W-1:0] SLOT_NONE = 4'd8;

    // Event classes handed from the decode stage to the relay stage.
    localparam logic [KIND_W-1:0] K_KEEP      = 3'd0;
    localparam logic [KIND_W-1:0] K_STORE     = 3'd1;
    localparam logic [KIND_W-1:0] K_BYPASS    = 3'd2;
    localparam logic [KIND_W-1:0] K_TO_PRESET = 3'd3;
    localparam logic [KIND_W-1:0] K_TO_LOOP   = 3'd4;
    localparam logic [KIND_W-1:0] K_TOGGLE    = 3'd5;
    localparam logic [KIND_W-1:0] K_RECALL    = 3'd6;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              pre_mode;
        logic              toggle_en;
        logic [IDX_W-1:0]  slot;
        logic [ADDR_W-1:0] addr;
        logic              mode;
        logic [BANK_W-1:0] bank;
        logic [IDX_W-1:0]  led;
    } t_op;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [MASK_W-1:0] data;
    } t_wr;

    function automatic logic [SLOT_W-1:0] code_slot(input logic [CODE_W-1:0] code);
        logic [SLOT_W-1:0] s;
        unique case (code)
            CODE_SLOT0: s = 4'd0;
            CODE_SLOT1: s = 4'd1;
            CODE_SLOT2: s = 4'd2;
            CODE_SLOT3: s = 4'd3;
            CODE_SLOT4: s = 4'd4;
            CODE_SLOT5: s = 4'd5;
            CODE_SLOT6: s = 4'd6;
            CODE_SLOT7: s = 4'd7;
            default:    s = SLOT_NONE;
        endcase
        return s;
    endfunction

    function automatic logic [BANK_W-1:0] next_bank(input logic [BANK_W-1:0] bank);
        logic [BANK_W:0] s;
        s = {1'b0, bank} + 3'd1;
        return (s >= 3'(NUM_BANKS)) ? '0 : s[BANK_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] store_addr(input logic [BANK_W-1:0] bank,
                                                     input logic [IDX_W-1:0]  idx);
        logic [7:0] a;
        a = 8'(bank) * 8'(PRESETS_PER_BANK) + 8'(idx);
        return a[ADDR_W-1:0];
    endfunction

endpackage

FILE: hdl/fsc_chan_if.sv
// Handshake channels of the footswitch controller: event input and result output.
// Depends on fsc_pkg.
interface fsc_in_if import fsc_pkg::*;;
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [CODE_W-1:0] switch_code;

    modport source (output valid, output cmd, output switch_code, input ready);
    modport sink   (input valid, input cmd, input switch_code, output ready);
endinterface

interface fsc_out_if import fsc_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MASK_W-1:0] relay_drive;
    logic              preset_mode;
    logic [BANK_W-1:0] bank_select;
    logic [IDX_W-1:0]  preset_led;
    logic              mute_pulse;

    modport source (output valid, output relay_drive, output preset_mode,
                    output bank_select, output preset_led, output mute_pulse,
                    input ready);
    modport sink   (input valid, input relay_drive, input preset_mode,
                    input bank_select, input preset_led, input mute_pulse,
                    output ready);
endinterface

FILE: hdl/fsc_store.sv
// Preset mask store: 32 x 8 synchronous RAM, one write and one registered read port.
// Valid bits make unwritten entries read as zero. Depends on fsc_pkg.
module fsc_store import fsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    input  t_wr               i_wr,
    output logic [MASK_W-1:0] o_rd_data
);

    logic [MASK_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]  r_valid;
    logic [MASK_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.en) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    // Write-first: a read that meets a write to the same entry takes the new data.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            if (i_wr.en && (i_wr.addr == i_rd_addr)) begin
                r_rd_data <= i_wr.data;
            end else if (r_valid[i_rd_addr]) begin
                r_rd_data <= r_mem[i_rd_addr];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/fsc_front.sv
// Decode stage: classifies a footswitch beat and keeps mode, bank and preset index.
// Depends on fsc_pkg.
module fsc_front import fsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic              i_cmd,
    input  logic [CODE_W-1:0] i_code,
    output t_op               o_op
);

    logic              r_mode;
    logic [BANK_W-1:0] r_bank;
    logic [IDX_W-1:0]  r_idx;

    logic              n_mode;
    logic [BANK_W-1:0] n_bank;
    logic [IDX_W-1:0]  n_idx;
    logic [KIND_W-1:0] w_kind;
    logic [SLOT_W-1:0] w_slot;
    logic              w_in_bank;
    logic              w_is_slot;

    assign w_slot    = code_slot(i_code);
    assign w_is_slot = (w_slot != SLOT_NONE);
    assign w_in_bank = (w_slot < 4'(PRESETS_PER_BANK));

    always_comb begin
        n_mode = r_mode;
        n_bank = r_bank;
        n_idx  = r_idx;
        w_kind = K_KEEP;
        priority if (i_code == CODE_ALL || i_code == CODE_NONE) begin
            w_kind = K_KEEP;
        end else if (!r_mode) begin
            priority if (i_cmd) begin
                w_kind = K_STORE;
                if (w_in_bank) n_idx = w_slot[IDX_W-1:0];
            end else if (i_code == CODE_BYPASS) begin
                w_kind = K_BYPASS;
            end else if (i_code == CODE_MODE) begin
                w_kind = K_TO_PRESET;
                n_mode = 1'b1;
            end else if (i_code == CODE_BANK) begin
                w_kind = K_KEEP;
                n_bank = next_bank(r_bank);
            end else begin
                w_kind = K_TOGGLE;
            end
        end else begin
            priority if (i_code == CODE_BYPASS) begin
                w_kind = K_BYPASS;
            end else if (i_code == CODE_MODE) begin
                w_kind = K_TO_LOOP;
                n_mode = 1'b0;
            end else begin
                w_kind = K_RECALL;
                if (i_code == CODE_BANK) n_bank = next_bank(r_bank);
                else if (w_in_bank)      n_idx  = w_slot[IDX_W-1:0];
            end
        end
    end

    always_comb begin
        o_op.kind      = w_kind;
        o_op.pre_mode  = r_mode;
        o_op.toggle_en = w_is_slot;
        o_op.slot      = w_slot[IDX_W-1:0];
        o_op.addr      = store_addr(n_bank, n_idx);
        o_op.mode      = n_mode;
        o_op.bank      = n_bank;
        o_op.led       = n_mode ? n_idx : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
            r_bank <= '0;
            r_idx  <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_bank <= n_bank;
            r_idx  <= n_idx;
        end
    end

endmodule

FILE: hdl/fsc_relay.sv
// Relay stage: applies a decoded event to relays, loop mask and bypass saves,
// issues store writes and holds the result register. Depends on fsc_pkg.
module fsc_relay import fsc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_op               i_op,
    input  logic [MASK_W-1:0] i_rd_data,
    input  logic              i_out_ready,
    output logic              o_can_load,
    output t_wr               o_wr,
    output logic              o_out_valid,
    output logic [MASK_W-1:0] o_relay_drive,
    output logic              o_preset_mode,
    output logic [BANK_W-1:0] o_bank_select,
    output logic [IDX_W-1:0]  o_preset_led,
    output logic              o_mute_pulse
);

    logic              r_b_valid;
    t_op               r_op;
    logic [MASK_W-1:0] r_relay;
    logic [MASK_W-1:0] r_loop;
    logic [MASK_W-1:0] r_sav_l;
    logic [MASK_W-1:0] r_sav_p;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_out_relay;
    logic              r_out_mode;
    logic [BANK_W-1:0] r_out_bank;
    logic [IDX_W-1:0]  r_out_led;
    logic              r_out_mute;

    logic [MASK_W-1:0] n_relay;
    logic [MASK_W-1:0] n_loop;
    logic [MASK_W-1:0] n_sav_l;
    logic [MASK_W-1:0] n_sav_p;
    logic              n_mute;
    logic [MASK_W-1:0] w_flip;
    logic              w_adv;

    assign w_adv      = r_b_valid && (!r_out_valid || i_out_ready);
    assign o_can_load = !r_b_valid || w_adv;
    assign w_flip     = r_op.toggle_en ? (MASK_W'(1) << r_op.slot) : '0;

    always_comb begin
        n_relay = r_relay;
        n_loop  = r_loop;
        n_sav_l = r_sav_l;
        n_sav_p = r_sav_p;
        n_mute  = 1'b0;
        unique case (r_op.kind)
            K_BYPASS: begin
                n_mute = 1'b1;
                if (r_relay == '0) begin
                    if (r_op.pre_mode) begin
                        n_relay = r_sav_p;
                    end else begin
                        n_relay = r_sav_l;
                        n_loop  = r_sav_l;
                    end
                end else begin
                    if (r_op.pre_mode) begin
                        n_sav_p = r_relay;
                    end else begin
                        n_sav_l = r_relay;
                        n_loop  = '0;
                    end
                    n_relay = '0;
                end
            end
            K_TO_PRESET, K_RECALL: begin
                n_relay = i_rd_data;
                n_mute  = 1'b1;
            end
            K_TO_LOOP: begin
                n_relay = r_loop;
            end
            K_TOGGLE: begin
                n_loop  = r_loop ^ w_flip;
                n_relay = r_loop ^ w_flip;
                n_mute  = 1'b1;
            end
            default: ;
        endcase
    end

    // Hold in loop mode stores the live loop mask into the selected preset.
    always_comb begin
        o_wr.en   = w_adv && (r_op.kind == K_STORE);
        o_wr.addr = r_op.addr;
        o_wr.data = r_loop;
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_relay     <= '0;
            r_loop      <= '0;
            r_sav_l     <= '0;
            r_sav_p     <= '0;
        end else begin
            if (i_load) begin
                r_b_valid <= 1'b1;
            end else if (w_adv) begin
                r_b_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_relay     <= n_relay;
                r_loop      <= n_loop;
                r_sav_l     <= n_sav_l;
                r_sav_p     <= n_sav_p;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_relay <= n_relay;
            r_out_mode  <= r_op.mode;
            r_out_bank  <= r_op.bank;
            r_out_led   <= r_op.led;
            r_out_mute  <= n_mute;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_relay_drive = r_out_relay;
    assign o_preset_mode = r_out_mode;
    assign o_bank_select = r_out_bank;
    assign o_preset_led  = r_out_led;
    assign o_mute_pulse  = r_out_mute;

endmodule

FILE: hdl/footswitch_loop_preset_controller_unit.sv
// Footswitch loop / preset controller, top level.
// A taken beat waits in stage B until the result register is free, then loads it.
// Throughput: one event per cycle while the output side takes results; the
//   preset store read on the accept edge and its write as stage B advances set that pace.
// Reset: synchronous, active low; clears mode, bank, masks and the preset store's
//   valid bits, so the block is ready for events as soon as reset is released.
module footswitch_loop_preset_controller_unit import fsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fsc_in_if.sink      i_in,
    fsc_out_if.source   o_out
);

    // Stage A (accept edge): decode the beat, advance mode / bank / preset
    // index, and read the preset store at the address the event lands on.
    // Stage B (when the result register is free): combine the read mask with relay state, write the
    // store on a loop-mode hold, and load the result register.
    // The store forwards a write that meets a read of the same entry, so a
    // hold followed at once by the switch to preset mode sees the new mask.

    t_op               w_op;
    t_wr               w_wr;
    logic              w_accept;
    logic              w_can_load;
    logic [MASK_W-1:0] w_rd_data;

    // Take a new beat whenever stage B is empty or drains this cycle; hold
    // ready low while reset is asserted so no beat is taken and dropped.
    assign i_in.ready = w_can_load && i_rst_n;
    assign w_accept   = i_in.valid && w_can_load && i_rst_n;

    fsc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_cmd    (i_in.cmd),
        .i_code   (i_in.switch_code),
        .o_op     (w_op)
    );

    fsc_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (w_accept),
        .i_rd_addr (w_op.addr),
        .i_wr      (w_wr),
        .o_rd_data (w_rd_data)
    );

    fsc_relay u_relay (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_accept),
        .i_op          (w_op),
        .i_rd_data     (w_rd_data),
        .i_out_ready   (o_out.ready),
        .o_can_load    (w_can_load),
        .o_wr          (w_wr),
        .o_out_valid   (o_out.valid),
        .o_relay_drive (o_out.relay_drive),
        .o_preset_mode (o_out.preset_mode),
        .o_bank_select (o_out.bank_select),
        .o_preset_led  (o_out.preset_led),
        .o_mute_pulse  (o_out.mute_pulse)
    );

endmodule

FILE: hdl/fsc_checker.sv
// Port-level checker for the footswitch controller, bound to the top level.
// Depends on fsc_pkg and footswitch_loop_preset_controller_unit_assert.svh.
`include "footswitch_loop_preset_controller_unit_assert.svh"

module fsc_checker import fsc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_out_mode,
    input logic [IDX_W-1:0] i_out_led
);

    logic [1:0] r_pend;
    logic       w_in_beat;
    logic       w_out_beat;

    assign w_in_beat  = i_in_valid && i_in_ready;
    assign w_out_beat = i_out_valid && i_out_ready;

    // Track beats inside the block: at most one in stage B and one in the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(w_in_beat) - 2'(w_out_beat);
        end
    end

    `FSC_ASSERT_RST(a_rst_idle, !i_rst_n |=> !i_out_valid, "result valid after reset")
    `FSC_ASSERT(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result beat dropped")
    `FSC_ASSERT(a_led_loop, i_out_valid && !i_out_mode |-> i_out_led == '0, "preset LED lit in loop mode")
    `FSC_ASSERT(a_no_phantom, i_out_valid |-> r_pend != 2'd0, "result without an event")
    `FSC_ASSERT(a_depth, r_pend != 2'd3, "more events inside than stages")

endmodule

bind footswitch_loop_preset_controller_unit fsc_checker u_fsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_mode  (o_out.preset_mode),
    .i_out_led   (o_out.preset_led)
);
